/* sv/mtd_pkg.sv */
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types, codes and the dot/dash lookup for the Morse text decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int unsigned MAX_SYMBOLS = 5;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_QUERY = 8'h3F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [2:0] {
    KIND_EMPTY = 3'd0,
    KIND_MORSE = 3'd1,
    KIND_SLASH = 3'd2,
    KIND_HASH  = 3'd3,
    KIND_BAD   = 3'd4
  } token_kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] letter;
    logic       has_letter;
    logic       message_end;
  } mtd_result_t;

  function automatic logic [7:0] lookup_morse(input logic [2:0] count,
                                              input logic [4:0] pattern);
    logic [7:0] ch;
    ch = CHAR_QUERY;
    case ({count, pattern})
      {3'd2, 5'b00010}: ch = "A";
      {3'd4, 5'b00001}: ch = "B";
      {3'd4, 5'b00101}: ch = "C";
      {3'd3, 5'b00001}: ch = "D";
      {3'd1, 5'b00000}: ch = "E";
      {3'd4, 5'b00100}: ch = "F";
      {3'd3, 5'b00011}: ch = "G";
      {3'd4, 5'b00000}: ch = "H";
      {3'd2, 5'b00000}: ch = "I";
      {3'd4, 5'b01110}: ch = "J";
      {3'd3, 5'b00101}: ch = "K";
      {3'd4, 5'b00010}: ch = "L";
      {3'd2, 5'b00011}: ch = "M";
      {3'd2, 5'b00001}: ch = "N";
      {3'd3, 5'b00111}: ch = "O";
      {3'd4, 5'b00110}: ch = "P";
      {3'd4, 5'b01011}: ch = "Q";
      {3'd3, 5'b00010}: ch = "R";
      {3'd3, 5'b00000}: ch = "S";
      {3'd1, 5'b00001}: ch = "T";
      {3'd3, 5'b00100}: ch = "U";
      {3'd4, 5'b01000}: ch = "V";
      {3'd3, 5'b00110}: ch = "W";
      {3'd4, 5'b01001}: ch = "X";
      {3'd4, 5'b01101}: ch = "Y";
      {3'd4, 5'b00011}: ch = "Z";
      {3'd5, 5'b11110}: ch = "1";
      {3'd5, 5'b11100}: ch = "2";
      {3'd5, 5'b11000}: ch = "3";
      {3'd5, 5'b10000}: ch = "4";
      {3'd5, 5'b00000}: ch = "5";
      {3'd5, 5'b00001}: ch = "6";
      {3'd5, 5'b00011}: ch = "7";
      {3'd5, 5'b00111}: ch = "8";
      {3'd5, 5'b01111}: ch = "9";
      {3'd5, 5'b11111}: ch = "0";
      default:          ch = CHAR_QUERY;
    endcase
    return ch;
  endfunction

endpackage

/* sv/mtd_token.sv */
// ----------------------------------------------------------------------------
// mtd_token
// Token register and per-byte decode: builds the pending dot/dash token and
// forms the result when whitespace or the end of message closes it.
// ----------------------------------------------------------------------------
module mtd_token
  import mtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  char_code,
  input  logic        end_of_message,
  output mtd_result_t result
);

  logic [4:0]  symbol_pattern, symbol_pattern_next;
  logic [2:0]  symbol_count, symbol_count_next;
  token_kind_t token_kind, token_kind_next;

  logic [4:0]  taken_pattern;
  logic [2:0]  taken_count;
  token_kind_t taken_kind;
  logic        ws, sym, dash, emit, have;
  logic [7:0]  ch;

  always_comb begin
    ws   = (char_code inside {[8'd9:8'd13], 8'd32});
    dash = (char_code == CHAR_DASH);
    sym  = dash || (char_code == CHAR_DOT);

    taken_pattern = symbol_pattern;
    taken_count   = symbol_count;
    taken_kind    = token_kind;
    if (!ws) begin
      if (token_kind == KIND_EMPTY) begin
        if (sym) begin
          taken_kind    = KIND_MORSE;
          taken_pattern = {4'b0000, dash};
          taken_count   = 3'd1;
        end else if (char_code == CHAR_SLASH) begin
          taken_kind = KIND_SLASH;
        end else if (char_code == CHAR_HASH) begin
          taken_kind = KIND_HASH;
        end else begin
          taken_kind = KIND_BAD;
        end
      end else if (token_kind == KIND_MORSE && sym &&
                   symbol_count < 3'(MAX_SYMBOLS)) begin
        if (dash) begin
          taken_pattern[symbol_count] = 1'b1;
        end
        taken_count = symbol_count + 3'd1;
      end else begin
        taken_kind = KIND_BAD;
      end
    end

    case (taken_kind)
      KIND_MORSE: begin
        ch   = lookup_morse(taken_count, taken_pattern);
        have = 1'b1;
      end
      KIND_HASH: begin
        ch   = CHAR_SPACE;
        have = 1'b1;
      end
      KIND_EMPTY, KIND_SLASH: begin
        ch   = 8'd0;
        have = 1'b0;
      end
      default: begin
        ch   = CHAR_QUERY;
        have = 1'b1;
      end
    endcase

    emit = ws || end_of_message;

    result.valid       = step && emit && (end_of_message || have);
    result.letter      = have ? ch : 8'd0;
    result.has_letter  = have;
    result.message_end = end_of_message;

    if (emit) begin
      symbol_pattern_next = 5'd0;
      symbol_count_next   = 3'd0;
      token_kind_next     = KIND_EMPTY;
    end else begin
      symbol_pattern_next = taken_pattern;
      symbol_count_next   = taken_count;
      token_kind_next     = taken_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_pattern <= 5'd0;
      symbol_count   <= 3'd0;
      token_kind     <= KIND_EMPTY;
    end else if (step) begin
      symbol_pattern <= symbol_pattern_next;
      symbol_count   <= symbol_count_next;
      token_kind     <= token_kind_next;
    end
  end

endmodule

/* sv/morse_text_decoder.sv */
// ----------------------------------------------------------------------------
// morse_text_decoder
// Decodes a stream of dot/dash text bytes into ASCII characters.
// ----------------------------------------------------------------------------
// Path from input transaction to result: input register, then result register;
//   bytes that close no token give no result. Throughput: one byte per cycle
//   unless stalled, limited by the single token register update.
// Reset: synchronous rst empties the pipeline and clears the pending token.
module morse_text_decoder
  import mtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] letter,
  output logic       has_letter,
  output logic       message_end
);

  logic        hold_valid;
  logic [7:0]  hold_code;
  logic        hold_eom;
  logic        out_free;
  logic        step;
  mtd_result_t result;

  assign out_free = !out_valid || !out_stall;
  assign step     = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  // Hold the accepted byte until the result side can advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_code <= char_code;
      hold_eom  <= end_of_message;
    end
  end

  mtd_token u_token (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .char_code      (hold_code),
    .end_of_message (hold_eom),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && result.valid) begin
      letter      <= result.letter;
      has_letter  <= result.has_letter;
      message_end <= result.message_end;
    end
  end

endmodule
